[rtl/sws_pkg.sv]
// Shared types and constants for the sliding window statistics block.
// Used by sws_ctrl, sws_datapath and sliding_window_stats_top; no dependencies.
`default_nettype none

package sws_pkg;

    localparam int unsigned DEFAULT_DEPTH = 8;
    localparam int unsigned SAMPLE_W      = 16;

    // Result field widths
    localparam int unsigned FILL_FIELD_W = 4;
    localparam int unsigned SUM_FIELD_W  = 19;
    localparam int unsigned MEAN_FIELD_W = 24;
    localparam int unsigned MEAN_FRAC_W  = 8;

    localparam int unsigned IN_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = FILL_FIELD_W + SUM_FIELD_W + MEAN_FIELD_W
                                           + 2 * SAMPLE_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds
    localparam logic REQ_PUSH    = 1'b0;
    localparam logic REQ_REWRITE = 1'b1;

    typedef struct packed {
        logic load;
        logic write;
        logic rd;
        logic div_load;
        logic div_step;
        logic publish;
    } sws_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic div_last;
    } sws_status_t;

endpackage

`default_nettype wire

[rtl/sliding_window_stats_top.sv]
// Sliding window statistics: count, sum, mean, max and min over the last
// WINDOW_DEPTH samples.
//
// Requests enter on the s_ group: s_tdata carries the sample, s_tuser[0] the
// request kind (0 push, 1 rewrite of the most recent sample). Each request
// yields exactly one result on the m_ group, in request order.
// One request is in work at a time. After acceptance the sample is written
// to the ring memory, the ring is walked (one entry per cycle) to fold the
// window into sum, max and min, and then the bit-serial restoring divider
// for the mean (one quotient bit per cycle) runs before the result enters
// the output register. A new request is taken once the previous one has
// reached the output register, so one result may wait in m_tdata while the
// next is computed.
// If the receiver stalls with a result still waiting, the block holds the
// finished result internally and takes no further request until it moves.
// Reset clears position and fill count and empties the output register
// (the ring memory itself is not cleared); the block is ready out of reset.
// Depends on sws_pkg, sws_ctrl and sws_datapath.
`default_nettype none

module sliding_window_stats_top
#(
    parameter int unsigned WINDOW_DEPTH = sws_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [sws_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] sample
    input  wire logic [0:0]                         s_tuser,   // [0] req_type
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [3:0] fill_count, [22:4] window_sum, [46:23] window_mean,
    // [62:47] window_max, [78:63] window_min, rest zero
    output logic [sws_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import sws_pkg::*;

    sws_cmd_t    cmd;
    sws_status_t status;

    logic                    out_free;
    logic [FILL_FIELD_W-1:0] fill_count;
    logic [SUM_FIELD_W-1:0]  window_sum;
    logic [MEAN_FIELD_W-1:0] window_mean;
    logic [SAMPLE_W-1:0]     window_max;
    logic [SAMPLE_W-1:0]     window_min;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    sws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    sws_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_req_type (s_tuser[0]),
        .in_sample   (s_tdata[SAMPLE_W-1:0]),
        .status      (status),
        .fill_count  (fill_count),
        .window_sum  (window_sum),
        .window_mean (window_mean),
        .window_max  (window_max),
        .window_min  (window_min)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.publish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            m_tdata_reg <= OUT_TDATA_W'({window_min, window_max, window_mean,
                                         window_sum, fill_count});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[rtl/sws_ctrl.sv]
// Controller for the sliding window statistics block: sequences write, walk,
// divide and hand-off. Depends on sws_pkg.
`default_nettype none

module sws_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                out_free,
    input  wire sws_pkg::sws_status_t status,
    output sws_pkg::sws_cmd_t        cmd,
    output logic                     in_ready
);
    import sws_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.rd = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read data is folded in at this edge
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sws_datapath.sv]
// Datapath for the sliding window statistics block: sample ring memory,
// position and fill count, accumulators and a restoring divider. Depends on sws_pkg.
`default_nettype none

module sws_datapath
#(
    parameter int unsigned WINDOW_DEPTH = sws_pkg::DEFAULT_DEPTH
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sws_pkg::sws_cmd_t                  cmd,
    input  wire logic                               in_req_type,
    input  wire logic [sws_pkg::SAMPLE_W-1:0]       in_sample,
    output sws_pkg::sws_status_t                    status,
    output logic [sws_pkg::FILL_FIELD_W-1:0]        fill_count,
    output logic [sws_pkg::SUM_FIELD_W-1:0]         window_sum,
    output logic [sws_pkg::MEAN_FIELD_W-1:0]        window_mean,
    output logic [sws_pkg::SAMPLE_W-1:0]            window_max,
    output logic [sws_pkg::SAMPLE_W-1:0]            window_min
);
    import sws_pkg::*;

    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int WLK_W     = CNT_W + 1;
    localparam int SUM_RAW_W = SAMPLE_W + CNT_W;
    localparam int SUM_W     = (SUM_RAW_W > SUM_FIELD_W) ? SUM_RAW_W : SUM_FIELD_W;
    localparam int CNT_X_W   = (CNT_W > FILL_FIELD_W) ? CNT_W : FILL_FIELD_W;
    localparam int DVD_W     = SUM_W + MEAN_FRAC_W;
    localparam int STEP_W    = $clog2(DVD_W);

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];

    logic                req_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic [PTR_W-1:0]    wp_reg,          wp_next;
    logic [CNT_W-1:0]    filled_reg,      filled_next;
    logic                slot0_valid_reg, slot0_valid_next;
    logic [PTR_W-1:0]    walk_idx_reg,    walk_idx_next;
    logic                rd_valid_reg;
    logic                rd_zero_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                acc_first_reg,   acc_first_next;
    logic [SUM_W-1:0]    sum_reg,         sum_next;
    logic [SAMPLE_W-1:0] max_reg,         max_next;
    logic [SAMPLE_W-1:0] min_reg,         min_next;
    logic [DVD_W-1:0]    q_reg,           q_next;
    logic [CNT_W-1:0]    rem_reg,         rem_next;
    logic [STEP_W-1:0]   step_reg,        step_next;

    logic [PTR_W-1:0]    last_slot;
    logic [PTR_W-1:0]    wr_slot;
    logic [CNT_W-1:0]    walk_count;
    logic [SAMPLE_W-1:0] rd_sample;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                div_ge;
    logic [CNT_X_W-1:0]  cnt_ext;

    always_comb
    begin
        if (wp_reg != '0)
        begin
            last_slot = wp_reg - 1'b1;
        end
        else if (filled_reg != '0)
        begin
            last_slot = PTR_W'(filled_reg - 1'b1);
        end
        else
        begin
            last_slot = '0;
        end
        wr_slot = (req_reg == REQ_PUSH) ? wp_reg : last_slot;
    end

    // Empty ring still reads slot 0 once for max and min
    assign walk_count       = (filled_reg == '0) ? CNT_W'(1) : filled_reg;
    assign status.walk_last = (WLK_W'(walk_idx_reg) + WLK_W'(1)) == WLK_W'(walk_count);
    assign status.div_last  = (step_reg == '0);

    assign rd_sample = rd_zero_reg ? '0 : rd_data_reg;

    assign trial  = {rem_reg, q_reg[DVD_W-1]};
    assign diff   = trial - {1'b0, filled_reg};
    assign div_ge = (trial >= {1'b0, filled_reg});

    always_comb
    begin
        wp_next          = wp_reg;
        filled_next      = filled_reg;
        slot0_valid_next = slot0_valid_reg;
        walk_idx_next    = walk_idx_reg;
        acc_first_next   = acc_first_reg;
        sum_next         = sum_reg;
        max_next         = max_reg;
        min_next         = min_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;

        if (cmd.write)
        begin
            if (req_reg == REQ_PUSH)
            begin
                wp_next = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
                if (filled_reg != FULL_CNT)
                begin
                    filled_next = filled_reg + 1'b1;
                end
            end
            if (wr_slot == '0)
            begin
                slot0_valid_next = 1'b1;
            end
            walk_idx_next  = '0;
            acc_first_next = 1'b1;
        end

        if (cmd.rd)
        begin
            walk_idx_next = walk_idx_reg + 1'b1;
        end

        if (rd_valid_reg)
        begin
            acc_first_next = 1'b0;
            if (acc_first_reg)
            begin
                sum_next = (filled_reg != '0) ? SUM_W'(rd_sample) : '0;
                max_next = rd_sample;
                min_next = rd_sample;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(rd_sample);
                if (rd_sample > max_reg)
                begin
                    max_next = rd_sample;
                end
                if (rd_sample < min_reg)
                begin
                    min_next = rd_sample;
                end
            end
        end

        if (cmd.div_load)
        begin
            q_next    = {sum_reg, {MEAN_FRAC_W{1'b0}}};
            rem_next  = '0;
            step_next = STEP_W'(DVD_W - 1);
        end
        else if (cmd.div_step)
        begin
            q_next    = {q_reg[DVD_W-2:0], div_ge};
            rem_next  = div_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            filled_reg      <= '0;
            slot0_valid_reg <= 1'b0;
            walk_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            acc_first_reg   <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            wp_reg          <= wp_next;
            filled_reg      <= filled_next;
            slot0_valid_reg <= slot0_valid_next;
            walk_idx_reg    <= walk_idx_next;
            rd_valid_reg    <= cmd.rd;
            acc_first_reg   <= acc_first_next;
            step_reg        <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= in_req_type;
            sample_reg <= in_sample;
        end
        if (cmd.rd)
        begin
            // slot 0 reads as zero until first written
            rd_zero_reg <= (walk_idx_reg == '0) && !slot0_valid_reg;
        end
        sum_reg <= sum_next;
        max_reg <= max_next;
        min_reg <= min_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            ring_mem[wr_slot] <= sample_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= ring_mem[walk_idx_reg];
        end
    end

    assign cnt_ext     = CNT_X_W'(filled_reg);
    assign fill_count  = cnt_ext[FILL_FIELD_W-1:0];
    assign window_sum  = sum_reg[SUM_FIELD_W-1:0];
    assign window_mean = (filled_reg == '0) ? '0 : q_reg[MEAN_FIELD_W-1:0];
    assign window_max  = max_reg;
    assign window_min  = min_reg;

endmodule

`default_nettype wire
